// File: hdl/ray_oriented_box_slab_test_macros.svh
// assertion macros used by the top-level design file
`ifndef RAY_ORIENTED_BOX_SLAB_TEST_MACROS_SVH
`define RAY_ORIENTED_BOX_SLAB_TEST_MACROS_SVH

// clocked implication check, off during reset
`define ROSB_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check, off during reset
`define ROSB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/rosb_pkg.sv
package rosb_pkg;

  localparam int FracBitsDefault = 16;
  localparam int QueueDepth      = 2;

  localparam logic [30:0] NearReset = 31'd6554;
  localparam logic [30:0] FarReset  = 31'd65536000;

  localparam logic CfgNear = 1'b0;
  localparam logic CfgFar  = 1'b1;

  typedef struct packed {
    logic signed [31:0] e;
    logic signed [31:0] f;
    logic signed [31:0] slab_lo;
    logic signed [31:0] slab_hi;
    logic               last_axis;
  } slab_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_UPD,
    BK_FIN
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: hdl/rosb_front.sv
module rosb_front #(
  parameter int FRAC_BITS = rosb_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [351:0]        in_data,
  input  logic                in_last,
  output logic                push,
  input  logic                full,
  output rosb_pkg::slab_item_t push_item
);
  localparam int AW = 64 - FRAC_BITS + 2;

  logic               busy;
  logic [2:0]         cnt;
  logic [351:0]       item;
  logic               last;
  logic signed [63:0] prod;
  logic signed [AW-1:0] e_acc;
  logic signed [AW-1:0] f_acc;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [AW-1:0] term;

  assign in_ready = !busy && !rst;
  assign push = busy && (cnt == 3'd7) && !full;

  // pair order: ax*dx, ay*dy, az*dz, then dir*axis for f
  always_comb begin
    unique case (cnt)
      3'd0:    begin op_a = item[31:0];   op_b = item[127:96];  end
      3'd1:    begin op_a = item[63:32];  op_b = item[159:128]; end
      3'd2:    begin op_a = item[95:64];  op_b = item[191:160]; end
      3'd3:    begin op_a = item[223:192]; op_b = item[31:0];   end
      3'd4:    begin op_a = item[255:224]; op_b = item[63:32];  end
      default: begin op_a = item[287:256]; op_b = item[95:64];  end
    endcase
  end

  // floor shift of the registered product
  assign term = AW'(prod >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end else if (cnt != 3'd7) begin
      cnt <= cnt + 3'd1;
    end else if (!full) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && in_valid) begin
      item  <= in_data;
      last  <= in_last;
      e_acc <= '0;
      f_acc <= '0;
    end else if (busy) begin
      if (cnt < 3'd6) prod <= op_a * op_b;
      if (cnt >= 3'd1 && cnt <= 3'd3) e_acc <= e_acc + term;
      else if (cnt >= 3'd4 && cnt <= 3'd6) f_acc <= f_acc + term;
    end
  end

  always_comb begin
    push_item.e         = rosb_pkg::sat32(66'(e_acc));
    push_item.f         = rosb_pkg::sat32(66'(f_acc));
    push_item.slab_lo   = item[319:288];
    push_item.slab_hi   = item[351:320];
    push_item.last_axis = last;
  end
endmodule

// File: hdl/rosb_queue.sv
module rosb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rosb_pkg::slab_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output rosb_pkg::slab_item_t pop_item
);
  localparam int PW = $clog2(rosb_pkg::QueueDepth);

  rosb_pkg::slab_item_t mem [rosb_pkg::QueueDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full     = (count == (PW+1)'(rosb_pkg::QueueDepth));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule

// File: hdl/rosb_div.sv
module rosb_div #(
  parameter int FRAC_BITS = rosb_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  localparam int NW = 33 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] dvd;
  logic [31:0]   dsr;
  logic [31:0]   rem;
  logic          neg;
  logic [32:0]   rem_sh;
  logic          take;
  logic [32:0]   num_mag;
  logic [32:0]   den_mag;

  assign num_mag = num[32] ? 33'(-num) : 33'(num);
  assign den_mag = den[31] ? 33'(-33'(den)) : 33'(den);
  assign rem_sh  = {rem, dvd[NW-1]};
  assign take    = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) busy <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= NW'(num_mag) << FRAC_BITS;
      dsr <= den_mag[31:0];
      rem <= '0;
      neg <= num[32] ^ den[31];
    end else if (busy) begin
      rem <= take ? 32'(rem_sh - {1'b0, dsr}) : rem_sh[31:0];
      dvd <= {dvd[NW-2:0], take};
    end
  end

  always_comb begin
    if (!neg) quot = (dvd > NW'(32'h7fffffff)) ? 32'sh7fffffff : dvd[31:0];
    else if (dvd > NW'(33'h080000000)) quot = 32'sh80000000;
    else quot = 32'(-dvd[31:0]);
  end
endmodule

// File: hdl/rosb_back.sv
module rosb_back #(
  parameter int FRAC_BITS = rosb_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  rosb_pkg::slab_item_t pop_item,
  output logic                 pop,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [30:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic signed [31:0]   out_dist
);
  localparam int SlabEps = ((1 << FRAC_BITS) + 500) / 1000;

  rosb_pkg::back_state_t state, state_next;
  rosb_pkg::slab_item_t  cur;
  logic [30:0]        near_clip;
  logic [30:0]        far_clip;
  logic signed [31:0] entry_t;
  logic signed [31:0] exit_t;
  logic               missed;
  logic               second;
  logic signed [31:0] t1;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] quot;
  logic signed [32:0] div_num;
  logic [32:0]        f_mag;
  logic               steep;
  logic               out_free;
  logic               emit;
  logic signed [31:0] lo_t;
  logic signed [31:0] hi_t;
  logic signed [31:0] exit_new;
  logic signed [31:0] entry_new;
  logic signed [32:0] lo_m_e;
  logic signed [32:0] hi_m_e;

  assign f_mag   = pop_item.f[31] ? 33'(-33'(pop_item.f)) : 33'(pop_item.f);
  assign steep   = f_mag > 33'(SlabEps);
  assign lo_m_e  = 33'(pop_item.slab_lo) - 33'(pop_item.e);
  assign hi_m_e  = 33'(pop_item.slab_hi) - 33'(pop_item.e);
  assign div_num = 33'(cur.e) + (second ? 33'(cur.slab_hi) : 33'(cur.slab_lo));
  assign out_free = !out_valid || out_ready;
  assign emit     = (state == rosb_pkg::BK_FIN) && cur.last_axis && out_free;

  assign lo_t      = (t1 > quot) ? quot : t1;
  assign hi_t      = (t1 > quot) ? t1 : quot;
  assign exit_new  = (hi_t < exit_t) ? hi_t : exit_t;
  assign entry_new = (lo_t > entry_t) ? lo_t : entry_t;

  rosb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (cur.f),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= rosb_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      rosb_pkg::BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          state_next = (!missed && steep) ? rosb_pkg::BK_DIV : rosb_pkg::BK_FIN;
        end
      end
      rosb_pkg::BK_DIV: if (div_done && second) state_next = rosb_pkg::BK_UPD;
      rosb_pkg::BK_UPD: state_next = rosb_pkg::BK_FIN;
      rosb_pkg::BK_FIN: if (!cur.last_axis || out_free) state_next = rosb_pkg::BK_IDLE;
      default: state_next = rosb_pkg::BK_IDLE;
    endcase
  end

  // first run starts the cycle after the pop, second one after the first ends
  always_ff @(posedge clk) begin
    if (rst) div_start <= 1'b0;
    else div_start <= (pop && !missed && steep) ||
                      (state == rosb_pkg::BK_DIV && div_done && !second);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= pop_item;
      second <= 1'b0;
    end else if (state == rosb_pkg::BK_DIV && div_done && !second) begin
      t1     <= quot;
      second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_clip <= rosb_pkg::NearReset;
      far_clip  <= rosb_pkg::FarReset;
      entry_t   <= 32'(rosb_pkg::NearReset);
      exit_t    <= 32'(rosb_pkg::FarReset);
      missed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          rosb_pkg::CfgNear: begin near_clip <= cfg_data; entry_t <= 32'(cfg_data); end
          rosb_pkg::CfgFar:  begin far_clip <= cfg_data;  exit_t <= 32'(cfg_data);  end
          default: ;
        endcase
      end else if (pop && !missed && !steep) begin
        if (lo_m_e > 33'sd0 || hi_m_e < 33'sd0) missed <= 1'b1;
      end else if (state == rosb_pkg::BK_DIV && div_done && second) begin
        exit_t  <= exit_new;
        entry_t <= entry_new;
        if (exit_new < entry_new) missed <= 1'b1;
      end else if (emit) begin
        out_hit   <= !missed;
        out_dist  <= missed ? 32'sd0 : entry_t;
        entry_t   <= 32'(near_clip);
        exit_t    <= 32'(far_clip);
        missed    <= 1'b0;
      end
    end
  end
endmodule

// File: hdl/ray_oriented_box_slab_test.sv
// channel   | direction | carries
// s_axis    | in        | one box axis of a ray, tlast on the final axis
// m_axis    | out       | hit flag and entry distance, one per ray
// cfg       | in        | near and far clip writes
//
// the front takes no new item until the previous one is pushed: six
// products through one 32x32 multiplier, then the item enters a two-entry queue
// the back runs a radix-2 divider twice on an axis with a steep direction
// and otherwise goes from the pop straight to the finish state
// reset is synchronous; the clip registers return to their reset values; a result
// waiting on m_tready stalls the back only at the last axis
`include "ray_oriented_box_slab_test_macros.svh"
module ray_oriented_box_slab_test #(
  parameter int FRAC_BITS = rosb_pkg::FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // axis_x, axis_y, axis_z, delta_x, delta_y, delta_z, dir_x, dir_y, dir_z,
  // slab_lo, slab_hi, 32 bits each
  input  logic [351:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit [0], hit_distance [32:1], zeros [39:33]
  output logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);
  rosb_pkg::slab_item_t push_item;
  rosb_pkg::slab_item_t pop_item;
  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  logic               out_hit;
  logic signed [31:0] out_dist;

  rosb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .push     (push),
    .full     (full),
    .push_item(push_item)
  );

  rosb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_item (pop_item)
  );

  rosb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_item (pop_item),
    .pop      (pop),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_hit  (out_hit),
    .out_dist (out_dist)
  );

  assign m_tdata = {7'd0, out_dist, out_hit};

  `ROSB_CHECK(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "miss with distance")
  `ROSB_CHECK_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took two items")
  `ROSB_CHECK(a_no_pop_empty, pop, !empty, "pop from empty queue")
endmodule

// File: test/ray_oriented_box_slab_test_check.sv
module ray_oriented_box_slab_test_check #(
  parameter int FRAC_BITS = rosb_pkg::FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [351:0] s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [39:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data,
  output int           fail_count,
  output int           rays_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SlabEps = ((64'sd1 <<< FRAC_BITS) + 500) / 1000;

  typedef struct {
    logic               hit;
    logic signed [31:0] entry_dist;
  } ray_verdict_t;

  ray_verdict_t verdicts[$];

  logic [30:0]        near_q, far_q;
  logic signed [31:0] entry_q, exit_q;
  logic               missed_q;

  function automatic logic signed [31:0] clamp_q(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] dot_q(input logic [95:0] a, input logic [95:0] b);
    logic signed [65:0] acc;
    logic signed [63:0] p;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      p = 64'($signed(a[32*k +: 32])) * 64'($signed(b[32*k +: 32]));
      acc = acc + 66'(p >>> FRAC_BITS);
    end
    return clamp_q(acc);
  endfunction

  function automatic logic signed [31:0] slab_time(input logic signed [31:0] e,
                                                   input logic signed [31:0] slab,
                                                   input logic signed [31:0] f);
    logic signed [63:0] num;
    num = (64'(e) + 64'(slab)) <<< FRAC_BITS;
    return clamp_q(66'(num / 64'(f)));
  endfunction

  task automatic take_axis(input logic [351:0] d, input logic last);
    logic signed [31:0] e, f, t1, t2, w, lo, hi;
    lo = d[319:288];
    hi = d[351:320];
    if (!missed_q) begin
      e = dot_q(d[95:0], d[191:96]);
      f = dot_q(d[287:192], d[95:0]);
      if ((f < 0 ? -64'(f) : 64'(f)) > SlabEps) begin
        t1 = slab_time(e, lo, f);
        t2 = slab_time(e, hi, f);
        if (t1 > t2) begin
          w = t1; t1 = t2; t2 = w;
        end
        if (t2 < exit_q) exit_q = t2;
        if (t1 > entry_q) entry_q = t1;
        if (exit_q < entry_q) missed_q = 1'b1;
      end else if (64'(lo) - 64'(e) > 0 || 64'(hi) - 64'(e) < 0) begin
        missed_q = 1'b1;
      end
    end
    if (last) begin
      verdicts.push_back('{hit: !missed_q, entry_dist: missed_q ? 32'sd0 : entry_q});
      entry_q = $signed({1'b0, near_q});
      exit_q = $signed({1'b0, far_q});
      missed_q = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    ray_verdict_t want;
    if (rst) begin
      near_q = rosb_pkg::NearReset;
      far_q = rosb_pkg::FarReset;
      entry_q = $signed({1'b0, near_q});
      exit_q = $signed({1'b0, far_q});
      missed_q = 1'b0;
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rosb_pkg::CfgNear) begin
          near_q = cfg_data;
          entry_q = $signed({1'b0, cfg_data});
        end else begin
          far_q = cfg_data;
          exit_q = $signed({1'b0, cfg_data});
        end
      end
      if (s_tvalid && s_tready) take_axis(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (verdicts.size() == 0) begin
          $error("result with nothing expected: %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = verdicts.pop_front();
          if (m_tdata[0] !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
            fail_count <= fail_count + 1;
          end else if ($signed(m_tdata[32:1]) !== want.entry_dist) begin
            $error("hit_distance: expected %0d, got %0d", want.entry_dist,
                   $signed(m_tdata[32:1]));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    rays_pending <= verdicts.size();
  end

endmodule

// File: test/tb_ray_oriented_box_slab_test.sv
module tb_ray_oriented_box_slab_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // axis_x, axis_y, axis_z, delta_x..z, dir_x..z, slab_lo, slab_hi, 32 bits each
  logic [351:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // hit [0], hit_distance [32:1], zeros [39:33]
  logic [39:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = rosb_pkg::CfgNear;
  logic [30:0]  cfg_data = '0;
  int           fail_count;
  int           rays_pending;
  logic         quiet = 1'b0;
  int           stall_left = 0;

  always #5 clk = ~clk;

  ray_oriented_box_slab_test uut (.*);
  ray_oriented_box_slab_test_check checker_i (.*);

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      stall_left <= quiet ? 0 : $urandom_range(0, 15);
      m_tready <= quiet || ($urandom_range(0, 1) == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] span(input int lim);
    return 32'($urandom_range(0, 2 * lim)) - 32'(lim);
  endfunction

  task automatic send_axis(input logic [351:0] d, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rays_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_clip(input logic idx, input logic [30:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed ray with random content, sometimes parallel to a slab
  task automatic send_ray();
    logic [351:0] d;
    for (int k = 0; k < 3; k++) begin
      d[95:0] = {span(65536), span(65536), span(65536)};
      d[191:96] = {span(1 << 22), span(1 << 22), span(1 << 22)};
      d[287:192] = ($urandom_range(0, 7) == 0) ? '0 : {span(65536), span(65536), span(65536)};
      d[319:288] = span(1 << 21);
      d[351:320] = span(1 << 21);
      send_axis(d, k == 2);
    end
  endtask

  task automatic random_phase(input int n);
    logic [351:0] d;
    int sent;
    sent = 0;
    quiet = ($urandom_range(0, 3) == 0);
    while (sent < n) begin
      if ($urandom_range(0, 5) == 0) begin
        for (int k = 0; k < 11; k++) d[32*k +: 32] = $urandom;
        send_axis(d, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_ray();
        sent += 3;
      end
    end
    send_axis({11{32'h0}}, 1'b1);
    settle();
  endtask

  initial begin
    logic [351:0] d;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, zero direction (parallel inside), parallel outside
    send_axis({11{32'h7fffffff}}, 1'b1);
    send_axis({11{32'h80000000}}, 1'b1);
    send_axis({11{32'h00000000}}, 1'b1);
    d = '0;
    d[319:288] = 32'd65536;
    send_axis(d, 1'b1);
    d[319:288] = 32'hffff0000;
    d[351:320] = 32'hffff8000;
    send_axis(d, 1'b1);
    // tiny direction just above and at the threshold, saturating quotients
    d = '0;
    d[31:0] = 32'd65536;
    d[223:192] = 32'd67;
    d[319:288] = 32'h80000000;
    d[351:320] = 32'h7fffffff;
    send_axis(d, 1'b0);
    d[223:192] = 32'hffffffbd;
    send_axis(d, 1'b0);
    d[223:192] = 32'd66;
    d[319:288] = 32'hffff0000;
    d[351:320] = 32'h00010000;
    send_axis(d, 1'b1);
    // unit box hit head on, then miss behind the ray
    for (int k = 0; k < 3; k++) begin
      d = '0;
      d[32*k +: 32] = 32'd65536;
      d[96 + 32*k +: 32] = (k == 0) ? 32'd655360 : 32'd0;
      d[192 +: 32] = 32'd65536;
      d[319:288] = 32'hffff0000;
      d[351:320] = 32'h00010000;
      send_axis(d, k == 2);
    end
    for (int k = 0; k < 3; k++) begin
      d = '0;
      d[32*k +: 32] = 32'd65536;
      d[96 + 32*k +: 32] = (k == 0) ? 32'hfff60000 : 32'd0;
      d[192 +: 32] = 32'd65536;
      d[319:288] = 32'hffff0000;
      d[351:320] = 32'h00010000;
      send_axis(d, k == 2);
    end
    settle();

    random_phase(330);
    write_clip(rosb_pkg::CfgNear, 31'd0);
    write_clip(rosb_pkg::CfgFar, 31'h7fffffff);
    random_phase(330);
    write_clip(rosb_pkg::CfgNear, 31'h7fffffff);
    write_clip(rosb_pkg::CfgFar, 31'd0);
    random_phase(100);
    write_clip(rosb_pkg::CfgNear, 31'($urandom_range(0, 1 << 20)));
    write_clip(rosb_pkg::CfgFar, 31'($urandom_range(1 << 20, 1 << 30)));
    random_phase(400);
    write_clip(rosb_pkg::CfgNear, rosb_pkg::NearReset);
    write_clip(rosb_pkg::CfgFar, rosb_pkg::FarReset);
    random_phase(470);

    if (fail_count == 0) $display("[ray_oriented_box_slab_test] OK");
    else $display("[ray_oriented_box_slab_test] ERROR");
    $finish;
  end

  initial begin
    #30ms;
    $display("[ray_oriented_box_slab_test] ERROR");
    $finish;
  end

endmodule
